@@ sv/bbc_pkg.sv @@
// bbc_pkg: shared types, codes and constants of the block buffer cache core
// used by bbc_scan and block_buffer_cache_lru_refcount_core
`timescale 1ns / 1ps

package bbc_pkg;

  localparam int NUM_BUFFERS_DEF = 32;
  localparam int RES_IDX_W       = 5;
  localparam int DEV_W           = 8;
  localparam int BLK_W           = 32;
  localparam int REFS_W          = 8;
  localparam int STAMP_W         = 32;

  localparam logic [REFS_W-1:0]  REFS_MAX    = '1;
  localparam logic [STAMP_W-1:0] STAMP_NEVER = '1;

  typedef enum logic [1:0] {
    CMD_GET     = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_PIN     = 2'd2,
    CMD_UNPIN   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_MISS   = 2'd1,
    ST_FULL   = 2'd2,
    ST_CNTERR = 2'd3
  } status_e;

  // one cache entry as held in the tag memory
  typedef struct packed {
    logic               valid;
    logic [DEV_W-1:0]   device;
    logic [BLK_W-1:0]   block;
    logic [REFS_W-1:0]  refs;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // scan unit control from the sequencer
  typedef struct packed {
    logic clear;
    logic sample;
  } scan_ctl_t;

endpackage

@@ sv/block_buffer_cache_lru_refcount_core.sv @@
// block_buffer_cache_lru_refcount_core: tag and reference-count manager top level
// depends on bbc_pkg, bbc_ram, bbc_scan
//
//   channel   signals                                                   dir  handshake
//   command   command_i device_number_i block_number_i buffer_index_i    in   start_i & !busy_o
//             now_tick_i
//   result    result_index_o status_o needs_read_o                      out  done_o, one cycle
//
// get runs a scan of one tag memory read per entry, a state for the last read data,
// a decide and write-back state, then the result cycle. release, pin and unpin run
// read, modify and write, then result; an out-of-range index gives its result in the
// cycle after accept.
// reset leaves the tag memory contents untouched; a per-entry written bit makes
// unwritten entries read as zero, so no clearing pass is needed.
// one item at a time; busy_o is high through the result cycle, results cannot be held off.
`timescale 1ns / 1ps

module block_buffer_cache_lru_refcount_core #(
  parameter int NUM_BUFFERS = bbc_pkg::NUM_BUFFERS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [1:0]                        command_i,
  input  logic [bbc_pkg::DEV_W-1:0]         device_number_i,
  input  logic [bbc_pkg::BLK_W-1:0]         block_number_i,
  input  logic [bbc_pkg::RES_IDX_W-1:0]     buffer_index_i,
  input  logic [bbc_pkg::STAMP_W-1:0]       now_tick_i,
  output logic                              done_o,
  output logic [bbc_pkg::RES_IDX_W-1:0]     result_index_o,
  output logic [1:0]                        status_o,
  output logic                              needs_read_o
);

  import bbc_pkg::*;

  localparam int IDX_W = $clog2(NUM_BUFFERS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUFFERS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_MOD,
    S_SCAN,
    S_END,
    S_DEC,
    S_RESP
  } state_e;

  state_e               state_q, state_d;
  logic [IDX_W-1:0]     addr_q, addr_d;
  logic                 done_q, done_d;
  logic [RES_IDX_W-1:0] res_idx_q, res_idx_d;
  status_e              status_q, status_d;
  logic                 rd_q, rd_d;

  cmd_e                 cmd_q;
  logic [DEV_W-1:0]     dev_q;
  logic [BLK_W-1:0]     blk_q;
  logic [STAMP_W-1:0]   now_q;

  logic                 rv_q;
  logic [IDX_W-1:0]     rd_idx_q;
  logic [NUM_BUFFERS-1:0] init_q;

  logic                 accept;
  logic                 oob;
  logic                 re;
  logic [IDX_W-1:0]     raddr;
  logic                 we;
  logic [IDX_W-1:0]     waddr;
  entry_t               wdata;
  logic [ENTRY_W-1:0]   rdata;
  entry_t               rd_entry;
  scan_ctl_t            scan_ctl;

  logic                 hit;
  logic [IDX_W-1:0]     hit_idx;
  entry_t               hit_entry;
  logic                 vic;
  logic [IDX_W-1:0]     vic_idx;
  logic [STAMP_W-1:0]   vic_stamp;

  bbc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_BUFFERS)
  ) u_tags (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // entries never written since reset read as all zero
  assign rd_entry = init_q[rd_idx_q] ? entry_t'(rdata) : entry_t'('0);

  bbc_scan #(
    .NUM_BUFFERS (NUM_BUFFERS)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (scan_ctl),
    .req_device_i (dev_q),
    .req_block_i  (blk_q),
    .entry_i      (rd_entry),
    .entry_idx_i  (rd_idx_q),
    .hit_o        (hit),
    .hit_idx_o    (hit_idx),
    .hit_entry_o  (hit_entry),
    .vic_o        (vic),
    .vic_idx_o    (vic_idx),
    .vic_stamp_o  (vic_stamp)
  );

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && !busy_o;
  assign oob    = 32'(buffer_index_i) >= 32'(NUM_BUFFERS);

  always_comb begin
    state_d   = state_q;
    addr_d    = addr_q;
    done_d    = 1'b0;
    res_idx_d = res_idx_q;
    status_d  = status_q;
    rd_d      = rd_q;
    re        = 1'b0;
    raddr     = addr_q;
    we        = 1'b0;
    waddr     = addr_q;
    wdata     = rd_entry;
    scan_ctl  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (cmd_e'(command_i) == CMD_GET) begin
            addr_d         = '0;
            scan_ctl.clear = 1'b1;
            state_d        = S_SCAN;
          end else if (oob) begin
            res_idx_d = buffer_index_i;
            status_d  = ST_CNTERR;
            rd_d      = 1'b0;
            done_d    = 1'b1;
            state_d   = S_RESP;
          end else begin
            addr_d  = IDX_W'(buffer_index_i);
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        re      = 1'b1;
        state_d = S_MOD;
      end
      S_MOD: begin
        res_idx_d = RES_IDX_W'(addr_q);
        rd_d      = 1'b0;
        status_d  = ST_OK;
        case (cmd_q) inside
          CMD_PIN: begin
            if (rd_entry.refs == REFS_MAX) begin
              status_d = ST_CNTERR;
            end else begin
              we         = 1'b1;
              wdata.refs = rd_entry.refs + REFS_W'(1);
            end
          end
          CMD_RELEASE, CMD_UNPIN: begin
            if (rd_entry.refs == '0) begin
              status_d = ST_CNTERR;
            end else begin
              we         = 1'b1;
              wdata.refs = rd_entry.refs - REFS_W'(1);
              // final release stamps the tick, unpin to zero does not
              if (cmd_q == CMD_RELEASE && rd_entry.refs == REFS_W'(1)) begin
                wdata.stamp = now_q;
              end
            end
          end
          default: begin
            status_d = ST_CNTERR;
          end
        endcase
        done_d  = 1'b1;
        state_d = S_RESP;
      end
      S_SCAN: begin
        re              = 1'b1;
        scan_ctl.sample = rv_q;
        addr_d          = addr_q + IDX_W'(1);
        if (addr_q == LAST_IDX) begin
          state_d = S_END;
        end
      end
      S_END: begin
        scan_ctl.sample = rv_q;
        state_d         = S_DEC;
      end
      S_DEC: begin
        if (hit) begin
          res_idx_d = RES_IDX_W'(hit_idx);
          if (hit_entry.refs == REFS_MAX) begin
            status_d = ST_CNTERR;
            rd_d     = 1'b0;
          end else begin
            we          = 1'b1;
            waddr       = hit_idx;
            wdata       = hit_entry;
            wdata.refs  = hit_entry.refs + REFS_W'(1);
            wdata.valid = 1'b1;
            status_d    = ST_OK;
            rd_d        = !hit_entry.valid;
          end
        end else if (vic) begin
          we           = 1'b1;
          waddr        = vic_idx;
          wdata.valid  = 1'b1;
          wdata.device = dev_q;
          wdata.block  = blk_q;
          wdata.refs   = REFS_W'(1);
          wdata.stamp  = vic_stamp;
          res_idx_d    = RES_IDX_W'(vic_idx);
          status_d     = ST_MISS;
          rd_d         = 1'b1;
        end else begin
          res_idx_d = '0;
          status_d  = ST_FULL;
          rd_d      = 1'b0;
        end
        done_d  = 1'b1;
        state_d = S_RESP;
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      addr_q    <= '0;
      done_q    <= 1'b0;
      res_idx_q <= '0;
      status_q  <= ST_OK;
      rd_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      addr_q    <= addr_d;
      done_q    <= done_d;
      res_idx_q <= res_idx_d;
      status_q  <= status_d;
      rd_q      <= rd_d;
    end
  end

  // read pipeline tracking and per-entry written bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q     <= 1'b0;
      rd_idx_q <= '0;
      init_q   <= '0;
    end else begin
      rv_q <= re;
      if (re) begin
        rd_idx_q <= raddr;
      end
      if (we) begin
        init_q[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_e'(command_i);
      dev_q <= device_number_i;
      blk_q <= block_number_i;
      now_q <= now_tick_i;
    end
  end

  assign done_o         = done_q;
  assign result_index_o = res_idx_q;
  assign status_o       = status_q;
  assign needs_read_o   = rd_q;

endmodule

@@ sv/bbc_ram.sv @@
// bbc_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module bbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/bbc_scan.sv @@
// bbc_scan: running match and oldest-free-entry tracker for the get scan
// depends on bbc_pkg
`timescale 1ns / 1ps

module bbc_scan #(
  parameter int NUM_BUFFERS = bbc_pkg::NUM_BUFFERS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bbc_pkg::scan_ctl_t             ctl_i,
  input  logic [bbc_pkg::DEV_W-1:0]      req_device_i,
  input  logic [bbc_pkg::BLK_W-1:0]      req_block_i,
  input  bbc_pkg::entry_t                entry_i,
  input  logic [$clog2(NUM_BUFFERS)-1:0] entry_idx_i,
  output logic                           hit_o,
  output logic [$clog2(NUM_BUFFERS)-1:0] hit_idx_o,
  output bbc_pkg::entry_t                hit_entry_o,
  output logic                           vic_o,
  output logic [$clog2(NUM_BUFFERS)-1:0] vic_idx_o,
  output logic [bbc_pkg::STAMP_W-1:0]    vic_stamp_o
);

  import bbc_pkg::*;

  localparam int IDX_W = $clog2(NUM_BUFFERS);

  logic               hit_q;
  logic               vic_q;
  logic [IDX_W-1:0]   hit_idx_q;
  logic [IDX_W-1:0]   vic_idx_q;
  entry_t             hit_entry_q;
  logic [STAMP_W-1:0] best_q;
  logic               match;
  logic               older;

  assign match = (entry_i.device == req_device_i) && (entry_i.block == req_block_i);
  // strict compare keeps the lowest index on a tie and never takes a never-stamp
  assign older = (entry_i.refs == '0) && (entry_i.stamp < best_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      vic_q  <= 1'b0;
      best_q <= STAMP_NEVER;
    end else if (ctl_i.clear) begin
      hit_q  <= 1'b0;
      vic_q  <= 1'b0;
      best_q <= STAMP_NEVER;
    end else if (ctl_i.sample) begin
      if (match) begin
        hit_q <= 1'b1;
      end
      if (older) begin
        vic_q  <= 1'b1;
        best_q <= entry_i.stamp;
      end
    end
  end

  // later matches overwrite, so the highest index wins
  always_ff @(posedge clk_i) begin
    if (ctl_i.sample && match) begin
      hit_idx_q   <= entry_idx_i;
      hit_entry_q <= entry_i;
    end
    if (ctl_i.sample && older) begin
      vic_idx_q <= entry_idx_i;
    end
  end

  assign hit_o       = hit_q;
  assign hit_idx_o   = hit_idx_q;
  assign hit_entry_o = hit_entry_q;
  assign vic_o       = vic_q;
  assign vic_idx_o   = vic_idx_q;
  assign vic_stamp_o = best_q;

endmodule
